@@ hw/rtl/lrtoa_pkg.sv @@
// Shared widths, constants, register codes and types for the LoRa time-on-air block.
// No dependencies; used by lrtoa_div and lora_time_on_air_top.
`timescale 1ns / 1ps

package lrtoa_pkg;

  localparam int LEN_W       = 8;
  localparam int SF_W        = 4;
  localparam int BW_W        = 19;
  localparam int CR_W        = 3;
  localparam int AIR_W       = 20;
  localparam int CFG_IDX_W   = 2;
  localparam int S_TDATA_W   = 8;
  localparam int M_TDATA_W   = 24;

  localparam int NUM_W       = 12;
  localparam int N_W         = 10;
  localparam int K_W         = 4;
  localparam int CR4_W       = 4;
  localparam int RECIP_W     = 14;
  localparam int RECIP_SHIFT = 16;
  localparam int BLK_W       = 7;
  localparam int PSYM_W      = 10;
  localparam int QTR_W       = 12;
  localparam int SCALED_W    = 20;
  localparam int PROD_W      = 32;
  localparam int HI_W        = PROD_W - AIR_W;

  localparam int FRONT_STAGES = 5;
  localparam int DIV_STEP     = 4;
  localparam int DIV_STAGES   = AIR_W / DIV_STEP;

  localparam logic [SF_W-1:0]   SF_MIN   = SF_W'(6);
  localparam logic [SF_W-1:0]   SF_MAX   = SF_W'(12);
  localparam logic [SF_W-1:0]   SF_LDRO  = SF_W'(11);
  localparam logic [SF_W-1:0]   SF_RESET = SF_W'(11);
  localparam logic [BW_W-1:0]   BW_LDRO  = BW_W'(125000);
  localparam logic [BW_W-1:0]   BW_RESET = BW_W'(250000);
  localparam logic [CR_W-1:0]   CR_MIN   = CR_W'(1);
  localparam logic [CR_W-1:0]   CR_MAX   = CR_W'(4);
  localparam logic [CR_W-1:0]   CR_RESET = CR_W'(1);
  localparam logic [CR4_W-1:0]  CR_OFFSET = CR4_W'(4);

  localparam logic [NUM_W-1:0]  LEN_OFFSET = NUM_W'(44);
  localparam logic [PSYM_W-1:0] PSYM_BASE  = PSYM_W'(8);
  localparam logic [QTR_W-1:0]  QTR_BASE   = QTR_W'(49);
  localparam logic [7:0]        MS_SCALE   = 8'd250;
  localparam logic [AIR_W-1:0]  AIR_MAX    = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPREADING = 2'd0,
    CFG_BANDWIDTH = 2'd1,
    CFG_CODING    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic            sat;
    logic [BW_W-1:0] rem;
    logic [AIR_W-1:0] low;
  } div_req_t;

  typedef struct packed {
    logic             sat;
    logic [BW_W-1:0]  rem;
    logic [AIR_W-1:0] low;
    logic [AIR_W-1:0] quot;
  } div_stage_t;

  // ceil(2^16 / k) for the symbol divisor k = SF - 2*DE
  function automatic logic [RECIP_W-1:0] recip(input logic [K_W-1:0] k);
    logic [RECIP_W-1:0] r;
    unique case (k)
      K_W'(6):  r = RECIP_W'(10923);
      K_W'(7):  r = RECIP_W'(9363);
      K_W'(8):  r = RECIP_W'(8192);
      K_W'(9):  r = RECIP_W'(7282);
      K_W'(10): r = RECIP_W'(6554);
      K_W'(11): r = RECIP_W'(5958);
      K_W'(12): r = RECIP_W'(5462);
      default:  r = RECIP_W'(8192);
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/lrtoa_div.sv @@
// Pipelined restoring divider: remainder-seeded dividend over bandwidth, four bits a stage.
// Depends on lrtoa_pkg; saturates the quotient when the request is flagged.
`timescale 1ns / 1ps

module lrtoa_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [lrtoa_pkg::BW_W-1:0]        bw,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lrtoa_pkg::div_req_t               in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lrtoa_pkg::AIR_W-1:0]       out_data
);

  localparam int NS = lrtoa_pkg::DIV_STAGES;

  logic [NS-1:0]           v;
  logic [NS-1:0]           rdy;
  lrtoa_pkg::div_stage_t   st      [NS];
  lrtoa_pkg::div_stage_t   st_next [NS];

  always_comb begin
    rdy[NS-1] = !v[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[NS-1];
  assign out_data  = st[NS-1].quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_stage
    lrtoa_pkg::div_stage_t src;

    if (i == 0) begin : g_first
      always_comb begin
        src.sat  = in_data.sat;
        src.rem  = in_data.rem;
        src.low  = in_data.low;
        src.quot = '0;
      end
    end else begin : g_rest
      assign src = st[i-1];
    end

    always_comb begin
      logic [lrtoa_pkg::BW_W:0] trial;
      st_next[i] = src;
      for (int j = 0; j < lrtoa_pkg::DIV_STEP; j++) begin
        trial = {st_next[i].rem, st_next[i].low[lrtoa_pkg::AIR_W-1]};
        st_next[i].low = st_next[i].low << 1;
        if (trial >= {1'b0, bw}) begin
          st_next[i].rem  = lrtoa_pkg::BW_W'(trial - {1'b0, bw});
          st_next[i].quot = {st_next[i].quot[lrtoa_pkg::AIR_W-2:0], 1'b1};
        end else begin
          st_next[i].rem  = trial[lrtoa_pkg::BW_W-1:0];
          st_next[i].quot = {st_next[i].quot[lrtoa_pkg::AIR_W-2:0], 1'b0};
        end
      end
      if (i == NS - 1 && src.sat) begin
        st_next[i].quot = lrtoa_pkg::AIR_MAX;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) begin
        st[i] <= st_next[i];
      end
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> (v == '0))
    else $error("divider not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (v[NS-1] && !out_ready) |=> (v[NS-1] && $stable(st[NS-1].quot)))
    else $error("stalled quotient lost or changed");

  a_first_hold: assert property (@(posedge clk) disable iff (rst)
    (v[0] && !rdy[0]) |=> (v[0] && $stable(st[0])))
    else $error("stalled first divider stage changed");

endmodule

@@ hw/rtl/lora_time_on_air_top.sv @@
// Top level of the LoRa time-on-air block: config registers, symbol math pipeline, divider.
// Depends on lrtoa_pkg and lrtoa_div.
//
//   channel   direction  handshake          payload
//   s_*       in         s_tvalid/s_tready  s_tdata[7:0] payload_length
//   m_*       out        m_tvalid/m_tready  m_tdata[19:0] airtime_ms
//   cfg_*     in         cfg_we             cfg_index, cfg_data
//
// One request per cycle is accepted unless a stall backs up the ready chain; m_tvalid rises
// once the request has passed five symbol stages and five divider stages, 4 quotient bits each.
// Reset clears all valid bits and loads SF 11, 250000 Hz, coding rate 1.
// A stall reaches s_tready in the same cycle through the ready chain; empty stages fill.
`timescale 1ns / 1ps

module lora_time_on_air_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [lrtoa_pkg::S_TDATA_W-1:0]     s_tdata,   // [7:0] payload_length
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [lrtoa_pkg::M_TDATA_W-1:0]     m_tdata,   // [19:0] airtime_ms, [23:20] zero
  input  logic                                cfg_we,
  input  logic [lrtoa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lrtoa_pkg::BW_W-1:0]          cfg_data
);

  localparam int NF = lrtoa_pkg::FRONT_STAGES;

  logic [lrtoa_pkg::SF_W-1:0] spreading_factor;
  logic [lrtoa_pkg::BW_W-1:0] bandwidth_hz;
  logic [lrtoa_pkg::CR_W-1:0] coding_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      spreading_factor <= lrtoa_pkg::SF_RESET;
      bandwidth_hz     <= lrtoa_pkg::BW_RESET;
      coding_rate      <= lrtoa_pkg::CR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lrtoa_pkg::CFG_SPREADING: spreading_factor <= cfg_data[lrtoa_pkg::SF_W-1:0];
        lrtoa_pkg::CFG_BANDWIDTH: bandwidth_hz     <= cfg_data;
        lrtoa_pkg::CFG_CODING:    coding_rate      <= cfg_data[lrtoa_pkg::CR_W-1:0];
        default: ;
      endcase
    end
  end

  logic [lrtoa_pkg::SF_W-1:0]    sf_c;
  logic [lrtoa_pkg::CR_W-1:0]    cr_c;
  logic [lrtoa_pkg::CR4_W-1:0]   cr4;
  logic                          de;
  logic [lrtoa_pkg::K_W-1:0]     k;
  logic [lrtoa_pkg::RECIP_W-1:0] k_recip;

  always_comb begin
    priority if (spreading_factor < lrtoa_pkg::SF_MIN) begin
      sf_c = lrtoa_pkg::SF_MIN;
    end else if (spreading_factor > lrtoa_pkg::SF_MAX) begin
      sf_c = lrtoa_pkg::SF_MAX;
    end else begin
      sf_c = spreading_factor;
    end
    priority if (coding_rate < lrtoa_pkg::CR_MIN) begin
      cr_c = lrtoa_pkg::CR_MIN;
    end else if (coding_rate > lrtoa_pkg::CR_MAX) begin
      cr_c = lrtoa_pkg::CR_MAX;
    end else begin
      cr_c = coding_rate;
    end
    cr4     = lrtoa_pkg::CR4_W'(cr_c) + lrtoa_pkg::CR_OFFSET;
    de      = (bandwidth_hz <= lrtoa_pkg::BW_LDRO) && (sf_c >= lrtoa_pkg::SF_LDRO);
    k       = sf_c - {2'b00, de, 1'b0};
    k_recip = lrtoa_pkg::recip(k);
  end

  logic [NF-1:0] v;
  logic [NF-1:0] rdy;
  logic          div_in_ready;

  always_comb begin
    rdy[NF-1] = !v[NF-1] || div_in_ready;
    for (int i = NF - 2; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign s_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= s_tvalid;
      end
      for (int i = 1; i < NF; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // stage 1: numerator (8L + 44 - 4SF), rounded up to quarters, biased for ceil by k
  logic [lrtoa_pkg::NUM_W-1:0] num;
  logic [lrtoa_pkg::NUM_W-1:0] neg;
  logic [lrtoa_pkg::NUM_W-1:0] diff;
  logic [lrtoa_pkg::N_W-1:0]   n_next;
  logic [lrtoa_pkg::N_W-1:0]   s1_n;

  always_comb begin
    num  = lrtoa_pkg::NUM_W'({s_tdata, 3'b000}) + lrtoa_pkg::LEN_OFFSET;
    neg  = lrtoa_pkg::NUM_W'({sf_c, 2'b00});
    diff = num - neg + lrtoa_pkg::NUM_W'(3);
    if (num > neg) begin
      n_next = lrtoa_pkg::N_W'(diff >> 2) + lrtoa_pkg::N_W'(k) - lrtoa_pkg::N_W'(1);
    end else begin
      n_next = lrtoa_pkg::N_W'(k) - lrtoa_pkg::N_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_n <= n_next;
    end
  end

  // stage 2: block count by reciprocal multiply
  logic [lrtoa_pkg::N_W+lrtoa_pkg::RECIP_W-1:0] blk_prod;
  logic [lrtoa_pkg::BLK_W-1:0]                  s2_blk;

  assign blk_prod = s1_n * k_recip;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_blk <= blk_prod[lrtoa_pkg::RECIP_SHIFT +: lrtoa_pkg::BLK_W];
    end
  end

  // stage 3: quarter symbols 49 + 4 * (8 + blocks * (CR + 4))
  logic [lrtoa_pkg::BLK_W+lrtoa_pkg::CR4_W-1:0] blk_cr;
  logic [lrtoa_pkg::PSYM_W-1:0]                 psym;
  logic [lrtoa_pkg::QTR_W-1:0]                  qtr_next;
  logic [lrtoa_pkg::QTR_W-1:0]                  s3_qtr;

  always_comb begin
    blk_cr   = s2_blk * cr4;
    psym     = lrtoa_pkg::PSYM_W'(blk_cr) + lrtoa_pkg::PSYM_BASE;
    qtr_next = lrtoa_pkg::QTR_BASE + {psym, 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s3_qtr <= qtr_next;
    end
  end

  // stage 4: scale to milliseconds
  logic [lrtoa_pkg::SCALED_W-1:0] scaled_next;
  logic [lrtoa_pkg::SCALED_W-1:0] s4_scaled;

  assign scaled_next = s3_qtr * lrtoa_pkg::MS_SCALE;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s4_scaled <= scaled_next;
    end
  end

  // stage 5: chips shift, overflow check, seed the divider remainder
  logic [lrtoa_pkg::PROD_W-1:0] prod;
  logic [lrtoa_pkg::HI_W-1:0]   prod_hi;
  lrtoa_pkg::div_req_t          req_next;
  lrtoa_pkg::div_req_t          s5_req;

  always_comb begin
    prod         = lrtoa_pkg::PROD_W'(s4_scaled) << sf_c;
    prod_hi      = prod[lrtoa_pkg::PROD_W-1 -: lrtoa_pkg::HI_W];
    req_next.sat = lrtoa_pkg::BW_W'(prod_hi) >= bandwidth_hz;
    req_next.rem = lrtoa_pkg::BW_W'(prod_hi);
    req_next.low = prod[lrtoa_pkg::AIR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s5_req <= req_next;
    end
  end

  logic [lrtoa_pkg::AIR_W-1:0] airtime_ms;

  lrtoa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .bw        (bandwidth_hz),
    .in_valid  (v[NF-1]),
    .in_ready  (div_in_ready),
    .in_data   (s5_req),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (airtime_ms)
  );

  assign m_tdata = lrtoa_pkg::M_TDATA_W'(airtime_ms);

  a_reset_empty: assert property (@(posedge clk) rst |=> (v == '0))
    else $error("front pipeline not empty after reset");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v[0])
    else $error("accepted request missing from first stage");

  a_handoff_hold: assert property (@(posedge clk) disable iff (rst)
    (v[NF-1] && !div_in_ready) |=> (v[NF-1] && $stable(s5_req)))
    else $error("request to divider dropped or changed while stalled");

endmodule
